FILE: hdl/lookahead_peak_limiter_unit_assert.svh
// assertion macros for the limiter checker
`ifndef LOOKAHEAD_PEAK_LIMITER_UNIT_ASSERT_SVH
`define LOOKAHEAD_PEAK_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define LPL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lpl assertion failed");

// next-cycle implication, quiet while reset is held
`define LPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lpl assertion failed");

`endif

FILE: hdl/lpl_pkg.sv
package lpl_pkg;

    // sample and gain formats
    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 20;
    localparam int GAIN_W   = FRAC_W + 1;
    localparam int OUT_W    = GAIN_W + 1;
    localparam int COEFF_W  = 20;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;

    // delay line geometry, one row holds left and right
    localparam int MAX_DELAY = 256;
    localparam int ADDR_W    = $clog2(MAX_DELAY);
    localparam int LEN_W     = $clog2(MAX_DELAY + 1);
    localparam int ROW_W     = 2 * SAMPLE_W;

    // reciprocal unit: one quotient bit per step
    localparam int QUO_STEPS = GAIN_W;
    localparam int STEP_W    = $clog2(QUO_STEPS);

    // config port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COEFF_W;

    localparam logic [GAIN_W-1:0]   UNITY_Q20     = GAIN_W'(1) << FRAC_W;
    localparam logic [SAMPLE_W-1:0] DIV_REM_INIT  = SAMPLE_W'(1) << (2 * FRAC_W - QUO_STEPS);
    localparam logic [COEFF_W-1:0]  RELEASE_RESET = COEFF_W'(1048303);
    localparam logic [LEN_W-1:0]    DELAY_RESET   = LEN_W'(240);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RELEASE_COEFF = 1'b0,
        REG_DELAY_LENGTH  = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PEAK,
        ST_DIV,
        ST_GAIN,
        ST_REL,
        ST_MUL_L,
        ST_MUL_R,
        ST_DONE
    } lpl_state_t;

    // magnitude of a signed sample, full negative maps to 2^23
    function automatic logic [SAMPLE_W-1:0] mag_of(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] r;
        r = s[SAMPLE_W-1] ? (~s + SAMPLE_W'(1)) : s;
        return r;
    endfunction

    // scale product back to Q20, clamp to unity, restore sign
    function automatic logic [OUT_W-1:0] gained_out(input logic neg,
                                                    input logic [PROD_W-1:0] prod);
        logic [PROD_W-FRAC_W-1:0] m;
        logic [GAIN_W-1:0]        mc;
        logic [OUT_W-1:0]         ms;
        m  = prod[PROD_W-1:FRAC_W];
        mc = (m > (PROD_W - FRAC_W)'(UNITY_Q20)) ? UNITY_Q20 : m[GAIN_W-1:0];
        ms = {1'b0, mc};
        return neg ? (~ms + OUT_W'(1)) : ms;
    endfunction

endpackage

FILE: hdl/lookahead_peak_limiter_unit.sv
// Lookahead peak limiter with hold for stereo Q3.20 audio frames. Each input transaction
// carries one left/right frame and a limit enable; each frame produces exactly one output
// transaction with the delayed, gained and clamped (+-1.0) samples and the gain in Q1.20.
// The gain drops at once to 1/peak when the frame peak exceeds 1.0, holds for delay_length
// frames, then releases exponentially by release_coeff. Frames are processed one at a time
// by a small sequencer around one reciprocal step unit and one 24x21 multiplier. A frame
// passes the peak step, the gain step and the left and right multiplies, skipping the
// gain step in bypass; when its peak is above 1.0 the reciprocal unit first produces one
// quotient bit per cycle, and a frame that triggers release adds a step to apply the release
// multiply. The sequencer returns to idle before the next frame is taken. The next frame
// is taken while a result waits in the output register; a frame that finishes while that
// result still waits stalls until it is handed over. After reset the delay memory is
// cleared one row per cycle, all 256 rows, during which no frame is accepted; config
// writes are always taken and should only be issued while the block is idle.
module lookahead_peak_limiter_unit
    import lpl_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    // config write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // frame input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [SAMPLE_W-1:0]   s_sample_left,
    input  logic signed [SAMPLE_W-1:0]   s_sample_right,
    input  logic                         s_limit_enable,
    // result output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [OUT_W-1:0]      m_out_left,
    output logic signed [OUT_W-1:0]      m_out_right,
    output logic [GAIN_W-1:0]            m_gain_now
);

    // sequencer
    lpl_state_t state_reg, state_next;

    // config registers
    logic [COEFF_W-1:0]  release_coeff_reg;
    logic [LEN_W-1:0]    delay_length_reg;

    // limiter state
    logic [GAIN_W-1:0]   gain_reg;
    logic [LEN_W-1:0]    hold_reg;
    logic [ADDR_W-1:0]   wi_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;

    // per-frame working registers
    logic [SAMPLE_W-1:0] smp_l_reg;
    logic [SAMPLE_W-1:0] smp_r_reg;
    logic                en_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic [GAIN_W-1:0]   req_reg;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [OUT_W-1:0]    left_res_reg;

    // delay memory, row = {right, left}
    logic [ROW_W-1:0]    delay_mem [MAX_DELAY];
    logic [ROW_W-1:0]    rd_data_reg;

    // output register
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_left_reg;
    logic [OUT_W-1:0]    out_right_reg;
    logic [GAIN_W-1:0]   gain_out_reg;

    // control decoded from state
    logic                busy_free;
    logic                mem_re;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ROW_W-1:0]    mem_wdata;
    logic                load_out;
    logic [SAMPLE_W-1:0] mul_a;
    logic [GAIN_W-1:0]   mul_b;

    // combinational helpers
    logic                out_free;
    logic [LEN_W-1:0]    len_eff;
    logic [ADDR_W-1:0]   wi_fix;
    logic [LEN_W-1:0]    wi_inc;
    logic [ADDR_W-1:0]   wi_wrap;
    logic [SAMPLE_W-1:0] mag_l;
    logic [SAMPLE_W-1:0] mag_r;
    logic [SAMPLE_W-1:0] peak_c;
    logic [SAMPLE_W:0]   rem_sh;
    logic                div_ge;
    logic [SAMPLE_W:0]   rem_sub;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;

    // delay length clamped to 1..MAX_DELAY
    always_comb begin
        if (delay_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (delay_length_reg > LEN_W'(MAX_DELAY)) begin
            len_eff = LEN_W'(MAX_DELAY);
        end else begin
            len_eff = delay_length_reg;
        end
    end

    // write index restarts when the length shrank below it
    assign wi_fix  = (LEN_W'(wi_reg) >= len_eff) ? '0 : wi_reg;
    assign wi_inc  = LEN_W'(wi_reg) + LEN_W'(1);
    assign wi_wrap = (wi_inc >= len_eff) ? '0 : wi_inc[ADDR_W-1:0];

    // frame peak across both channels
    assign mag_l  = mag_of(smp_l_reg);
    assign mag_r  = mag_of(smp_r_reg);
    assign peak_c = (mag_r > mag_l) ? mag_r : mag_l;

    // restoring division step for 2^40 / peak
    assign rem_sh  = {rem_reg, 1'b0};
    assign div_ge  = rem_sh >= {1'b0, peak_reg};
    assign rem_sub = rem_sh - {1'b0, peak_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == ADDR_W'(MAX_DELAY - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK: begin
                priority if (!en_reg) begin
                    state_next = ST_MUL_L;
                end else if (peak_c > SAMPLE_W'(UNITY_Q20)) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_GAIN;
                end
            end
            ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                if (req_reg < gain_reg || hold_reg != '0) begin
                    state_next = ST_MUL_L;
                end else begin
                    state_next = ST_REL;
                end
            end
            ST_REL:   state_next = ST_MUL_L;
            ST_MUL_L: state_next = ST_MUL_R;
            ST_MUL_R: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    // state decoded controls
    always_comb begin
        busy_free = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = wi_reg;
        mem_wdata = {smp_r_reg, smp_l_reg};
        load_out  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                busy_free = 1'b1;
                mem_re    = s_valid;
            end
            ST_GAIN: begin
                // release step operands: r * (req - gain)
                mul_a = SAMPLE_W'(release_coeff_reg);
                mul_b = req_reg - gain_reg;
            end
            ST_MUL_L: begin
                mul_a = mag_of(rd_data_reg[SAMPLE_W-1:0]);
                mul_b = gain_reg;
            end
            ST_MUL_R: begin
                mul_a = mag_of(rd_data_reg[ROW_W-1:SAMPLE_W]);
                mul_b = gain_reg;
            end
            ST_DONE: begin
                // right product stays in place while the result waits
                mul_a    = mag_of(rd_data_reg[ROW_W-1:SAMPLE_W]);
                mul_b    = gain_reg;
                // new samples go in only when the result is handed over
                mem_we   = out_free;
                load_out = out_free;
            end
            default: begin
                busy_free = 1'b0;
            end
        endcase
    end

    assign s_ready = busy_free;

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            release_coeff_reg <= RELEASE_RESET;
            delay_length_reg  <= DELAY_RESET;
            gain_reg          <= UNITY_Q20;
            hold_reg          <= '0;
            wi_reg            <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_RELEASE_COEFF: release_coeff_reg <= cfg_data[COEFF_W-1:0];
                    REG_DELAY_LENGTH:  delay_length_reg  <= cfg_data[LEN_W-1:0];
                endcase
            end

            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end

            if (state_reg == ST_IDLE && s_valid) begin
                wi_reg <= wi_fix;
            end

            // bypass: unity gain, no hold
            if (state_reg == ST_PEAK && !en_reg) begin
                gain_reg <= UNITY_Q20;
                hold_reg <= '0;
            end

            // attack reloads the hold, otherwise the hold counts down
            if (state_reg == ST_GAIN) begin
                if (req_reg < gain_reg) begin
                    gain_reg <= req_reg;
                    hold_reg <= len_eff;
                end else if (hold_reg != '0) begin
                    hold_reg <= hold_reg - LEN_W'(1);
                end
            end

            // release toward the required gain
            if (state_reg == ST_REL) begin
                gain_reg <= req_reg - prod_reg[FRAC_W +: GAIN_W];
            end

            if (load_out) begin
                wi_reg        <= wi_wrap;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers and the shared units
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);

        if (state_reg == ST_IDLE && s_valid) begin
            smp_l_reg <= s_sample_left;
            smp_r_reg <= s_sample_right;
            en_reg    <= s_limit_enable;
        end

        if (state_reg == ST_PEAK) begin
            peak_reg <= peak_c;
            req_reg  <= UNITY_Q20;
            rem_reg  <= DIV_REM_INIT;
            step_reg <= STEP_W'(QUO_STEPS - 1);
        end

        // one quotient bit per cycle, msb first
        if (state_reg == ST_DIV) begin
            rem_reg  <= div_ge ? rem_sub[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
            req_reg  <= {req_reg[GAIN_W-2:0], div_ge};
            step_reg <= step_reg - STEP_W'(1);
        end

        if (state_reg == ST_MUL_R) begin
            left_res_reg <= gained_out(rd_data_reg[SAMPLE_W-1], prod_reg);
        end

        if (load_out) begin
            out_left_reg  <= left_res_reg;
            out_right_reg <= gained_out(rd_data_reg[ROW_W-1], prod_reg);
            gain_out_reg  <= gain_reg;
        end
    end

    // delay memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            delay_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= delay_mem[wi_fix];
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_left  = out_left_reg;
    assign m_out_right = out_right_reg;
    assign m_gain_now  = gain_out_reg;

endmodule

FILE: hdl/lpl_checker.sv
`include "lookahead_peak_limiter_unit_assert.svh"

module lpl_checker
    import lpl_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic signed [SAMPLE_W-1:0]   s_sample_left,
    input  logic signed [SAMPLE_W-1:0]   s_sample_right,
    input  logic                         s_limit_enable,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [OUT_W-1:0]      m_out_left,
    input  logic signed [OUT_W-1:0]      m_out_right,
    input  logic [GAIN_W-1:0]            m_gain_now
);

    // a stalled result holds
    `LPL_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_out_left) && $stable(m_out_right) && $stable(m_gain_now))

    // one frame at a time: busy right after a frame is taken
    `LPL_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // gain never above unity
    `LPL_ASSERT_NOW(a_gain_range, m_valid, m_gain_now <= UNITY_Q20)

    // outputs clamped to +-1.0
    `LPL_ASSERT_NOW(a_out_clamp, m_valid, m_out_left >= -$signed({1'b0, UNITY_Q20}) && m_out_left <= $signed({1'b0, UNITY_Q20}) && m_out_right >= -$signed({1'b0, UNITY_Q20}) && m_out_right <= $signed({1'b0, UNITY_Q20}))

endmodule

bind lookahead_peak_limiter_unit lpl_checker u_lpl_checker (.*);
